// ----- src/btsp_pkg.sv -----
`default_nettype none

package btsp_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    localparam int COORD_W   = 10;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 2;
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 24;

    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_LVL_W = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic               pix;
        logic               edge_pix;
        logic [COORD_W-1:0] row_a;
        logic [COORD_W-1:0] col_a;
        logic [COORD_W-1:0] row_b;
        logic [COORD_W-1:0] col_b;
        logic               has_a;
        logic               has_b;
        logic               a_is_edge;
        logic               a_decide;
        logic               frame_end;
    } t_s1_info;

    typedef struct packed {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic               pixel;
        logic               removed;
        logic               run_end;
        logic               frame_end;
    } t_result;

    typedef struct packed {
        logic    valid_a;
        logic    valid_b;
        t_result res_a;
        t_result res_b;
    } t_push;

endpackage

`default_nettype wire

// ----- src/btsp_line_mem.sv -----
`default_nettype none

module btsp_line_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  wire logic          i_clk,
    input  wire logic          i_rd_en,
    input  wire logic [AW-1:0] i_rd_addr,
    input  wire logic          i_wr_en,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire logic [1:0]    i_wr_data,
    output logic [1:0]         o_rdata
);

    logic [1:0] r_mem [DEPTH];
    logic [1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rdata <= r_mem[i_rd_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- src/btsp_window.sv -----
`default_nettype none

module btsp_window (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire btsp_pkg::t_s1_info i_info,
    input  wire logic [1:0]        i_rdata,
    input  wire logic              i_subpass,
    output btsp_pkg::t_push        o_push
);

    import btsp_pkg::*;

    logic [8:0] r_window;
    logic [8:0] n_window;
    logic [2:0] w_newcol;
    logic       p2, p3, p4, p5, p6, p7, p8, p9, ctr;
    logic [3:0] w_trans;
    logic [3:0] w_count;
    logic       w_m1, w_m2;
    logic       w_remove;
    logic       w_pv;

    assign w_newcol = {i_info.pix, i_rdata[1], i_rdata[0]};
    assign n_window = {w_newcol, r_window[8:3]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= '0;
        end else if (i_valid) begin
            r_window <= n_window;
        end
    end

    assign p9  = n_window[0];
    assign p8  = n_window[1];
    assign p7  = n_window[2];
    assign p2  = n_window[3];
    assign ctr = n_window[4];
    assign p6  = n_window[5];
    assign p3  = n_window[6];
    assign p4  = n_window[7];
    assign p5  = n_window[8];

    assign w_trans = {3'b000, ~p2 & p3} + {3'b000, ~p3 & p4} + {3'b000, ~p4 & p5}
                   + {3'b000, ~p5 & p6} + {3'b000, ~p6 & p7} + {3'b000, ~p7 & p8}
                   + {3'b000, ~p8 & p9} + {3'b000, ~p9 & p2};
    assign w_count = {3'b000, p2} + {3'b000, p3} + {3'b000, p4} + {3'b000, p5}
                   + {3'b000, p6} + {3'b000, p7} + {3'b000, p8} + {3'b000, p9};

    assign w_m1 = i_subpass ? (p2 & p4 & p8) : (p2 & p4 & p6);
    assign w_m2 = i_subpass ? (p2 & p6 & p8) : (p4 & p6 & p8);

    assign w_remove = i_info.a_decide & ctr & (w_trans == 4'd1)
                    & (w_count >= 4'd2) & (w_count <= 4'd6) & ~w_m1 & ~w_m2;
    assign w_pv = ctr & ~w_remove;

    always_comb begin
        o_push.valid_a           = i_valid & i_info.has_a;
        o_push.valid_b           = i_valid & i_info.has_b;
        o_push.res_a.row         = i_info.row_a;
        o_push.res_a.col         = i_info.col_a;
        o_push.res_a.pixel       = i_info.a_is_edge ? i_info.edge_pix : w_pv;
        o_push.res_a.removed     = ~i_info.a_is_edge & w_remove;
        o_push.res_a.run_end     = ~i_info.has_b;
        o_push.res_a.frame_end   = 1'b0;
        o_push.res_b.row         = i_info.row_b;
        o_push.res_b.col         = i_info.col_b;
        o_push.res_b.pixel       = i_info.pix;
        o_push.res_b.removed     = 1'b0;
        o_push.res_b.run_end     = 1'b1;
        o_push.res_b.frame_end   = i_info.frame_end;
    end

endmodule

`default_nettype wire

// ----- src/btsp_out_fifo.sv -----
`default_nettype none

module btsp_out_fifo (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire btsp_pkg::t_push                i_push,
    input  wire logic                           i_pop,
    output btsp_pkg::t_result                   o_head,
    output logic                                o_valid,
    output logic [btsp_pkg::FIFO_LVL_W-1:0]     o_level
);

    import btsp_pkg::*;

    t_result                r_buf [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]  r_wptr;
    logic [FIFO_PTR_W-1:0]  r_rptr;
    logic [FIFO_LVL_W-1:0]  r_level;
    logic [FIFO_PTR_W-1:0]  w_wptr_p1;
    logic [FIFO_LVL_W-1:0]  w_npush;
    t_result                w_first;
    logic                   w_pop;

    assign w_wptr_p1 = r_wptr + 1'b1;
    assign w_npush   = {{(FIFO_LVL_W-1){1'b0}}, i_push.valid_a}
                     + {{(FIFO_LVL_W-1){1'b0}}, i_push.valid_b};
    assign w_first   = i_push.valid_a ? i_push.res_a : i_push.res_b;
    assign w_pop     = i_pop & (r_level != '0);

    always_ff @(posedge i_clk) begin
        if (i_push.valid_a | i_push.valid_b) begin
            r_buf[r_wptr] <= w_first;
        end
        if (i_push.valid_a & i_push.valid_b) begin
            r_buf[w_wptr_p1] <= i_push.res_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_level <= '0;
        end else begin
            r_wptr  <= r_wptr + w_npush[FIFO_PTR_W-1:0];
            r_level <= r_level + w_npush - {{(FIFO_LVL_W-1){1'b0}}, w_pop};
            if (w_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
        end
    end

    assign o_head  = r_buf[r_rptr];
    assign o_valid = (r_level != '0);
    assign o_level = r_level;

endmodule

`default_nettype wire

// ----- src/binary_thinning_subpass_core.sv -----
`default_nettype none

// Channel   Direction  Ports               Word contents (lowest bit up)
// s_axis    in         tvalid/tready/tdata  tdata: pixel_in, zero pad to 8 bits
// m_axis    out        tvalid/tready/tdata  tdata: out_row, out_col, pixel_out, run_end
//                      tuser/tlast          tuser: removed; tlast: frame_end
// cfg       in         we/index/data        0 frame_width, 1 frame_height, 2 subpass
//
// One pixel is taken per cycle unless input stalls; the line store is read on acceptance
// and written back in the following cycle, when the results are also queued.
// Rows that return two results (the last row) drain at one word per cycle while the
// output is ready, so input is then held back by the output port.
// Reset is synchronous; the line store needs no clearing since every entry used by
// a decision is written earlier in the same frame. Input stalls when the output
// queue could not hold the results of the pixels in flight.

module binary_thinning_subpass_core #(
    parameter int MAX_WIDTH  = btsp_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = btsp_pkg::DEF_MAX_HEIGHT
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    input  wire logic [btsp_pkg::S_TDATA_W-1:0]  i_s_axis_tdata,  // pixel_in
    output logic                                 o_m_axis_tvalid,
    input  wire logic                            i_m_axis_tready,
    // out_row, out_col, pixel_out, run_end
    output logic [btsp_pkg::M_TDATA_W-1:0]       o_m_axis_tdata,
    output logic                                 o_m_axis_tuser,  // removed
    output logic                                 o_m_axis_tlast,
    input  wire logic                            i_cfg_we,
    input  wire logic [btsp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [btsp_pkg::CFG_W-1:0]      i_cfg_data
);

    import btsp_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SUBPASS      = 2'd2;

    function automatic logic [31:0] clamp_m1(input logic [CFG_W-1:0] v, input int hi);
        logic [31:0] t;
        t = 32'(v);
        if (t < 32'd3) begin
            t = 32'd3;
        end else if (t > 32'(hi)) begin
            t = 32'(hi);
        end
        return t - 32'd1;
    endfunction

    logic [CFG_W-1:0]      r_frame_width;
    logic [CFG_W-1:0]      r_frame_height;
    logic                  r_subpass;
    logic [CW-1:0]         r_col;
    logic [RW-1:0]         r_row;
    logic                  r_prev_pix;
    logic                  r_s1_valid;
    logic [CW-1:0]         r_s1_addr;
    t_s1_info              r_s1_info;
    t_s1_info              n_s1_info;

    logic [31:0]           w_w_m1_32;
    logic [31:0]           w_h_m1_32;
    logic [CW-1:0]         w_w_m1;
    logic [RW-1:0]         w_h_m1;
    logic [31:0]           w_row32;
    logic [31:0]           w_col32;
    logic [31:0]           w_row_dec;
    logic [31:0]           w_col_dec;
    logic                  w_last_row;
    logic                  w_last_col;
    logic                  w_accept;
    logic                  w_pix;
    logic [1:0]            w_rdata;
    t_push                 w_push;
    t_result               w_head;
    logic                  w_out_valid;
    logic [FIFO_LVL_W-1:0] w_level;
    logic [FIFO_LVL_W:0]   w_reserve;
    logic                  w_size_write;

    assign w_w_m1_32 = clamp_m1(r_frame_width, MAX_WIDTH);
    assign w_h_m1_32 = clamp_m1(r_frame_height, MAX_HEIGHT);
    assign w_w_m1    = w_w_m1_32[CW-1:0];
    assign w_h_m1    = w_h_m1_32[RW-1:0];

    assign w_row32    = 32'(r_row);
    assign w_col32    = 32'(r_col);
    assign w_row_dec  = w_row32 - 32'd1;
    assign w_col_dec  = w_col32 - 32'd1;
    assign w_last_row = (r_row >= w_h_m1);
    assign w_last_col = (r_col >= w_w_m1);
    assign w_pix      = i_s_axis_tdata[0];

    assign w_reserve       = {1'b0, w_level} + (r_s1_valid ? (FIFO_LVL_W+1)'(2) : '0);
    assign o_s_axis_tready = (w_reserve <= (FIFO_LVL_W+1)'(FIFO_DEPTH - 2));
    assign w_accept        = i_s_axis_tvalid & o_s_axis_tready;

    assign w_size_write = i_cfg_we
                       & ((i_cfg_index == CFG_FRAME_WIDTH) | (i_cfg_index == CFG_FRAME_HEIGHT));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= 11'd1024;
            r_frame_height <= 11'd1024;
            r_subpass      <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_FRAME_WIDTH: begin
                    r_frame_width <= i_cfg_data;
                end
                CFG_FRAME_HEIGHT: begin
                    r_frame_height <= i_cfg_data;
                end
                CFG_SUBPASS: begin
                    r_subpass <= i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= w_accept;
            if (w_size_write) begin
                r_col <= '0;
                r_row <= '0;
            end else if (w_accept) begin
                if (w_last_col) begin
                    r_col <= '0;
                    r_row <= w_last_row ? '0 : r_row + 1'b1;
                end else begin
                    r_col <= r_col + 1'b1;
                end
            end
        end
    end

    always_comb begin
        n_s1_info.pix       = w_pix;
        n_s1_info.edge_pix  = r_prev_pix;
        n_s1_info.row_a     = w_row_dec[COORD_W-1:0];
        n_s1_info.col_a     = (r_col == '0) ? w_w_m1_32[COORD_W-1:0] : w_col_dec[COORD_W-1:0];
        n_s1_info.row_b     = w_row32[COORD_W-1:0];
        n_s1_info.col_b     = w_col32[COORD_W-1:0];
        n_s1_info.has_a     = (w_row32 >= 32'd2);
        n_s1_info.has_b     = (r_row == '0) | w_last_row;
        n_s1_info.a_is_edge = (r_col == '0);
        n_s1_info.a_decide  = (w_col32 >= 32'd2);
        n_s1_info.frame_end = w_last_row & w_last_col;
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_prev_pix <= w_pix;
            r_s1_addr  <= r_col;
            r_s1_info  <= n_s1_info;
        end
    end

    btsp_line_mem #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_line_mem (
        .i_clk     (i_clk),
        .i_rd_en   (w_accept),
        .i_rd_addr (r_col),
        .i_wr_en   (r_s1_valid),
        .i_wr_addr (r_s1_addr),
        .i_wr_data ({r_s1_info.pix, w_rdata[1]}),
        .o_rdata   (w_rdata)
    );

    btsp_window u_window (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (r_s1_valid),
        .i_info    (r_s1_info),
        .i_rdata   (w_rdata),
        .i_subpass (r_subpass),
        .o_push    (w_push)
    );

    btsp_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (i_m_axis_tready),
        .o_head  (w_head),
        .o_valid (w_out_valid),
        .o_level (w_level)
    );

    assign o_m_axis_tvalid = w_out_valid;
    assign o_m_axis_tdata  = {2'b00, w_head.run_end, w_head.pixel, w_head.col, w_head.row};
    assign o_m_axis_tuser  = w_head.removed;
    assign o_m_axis_tlast  = w_head.frame_end;

    a_no_same_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && r_s1_valid) |-> (r_col != r_s1_addr))
        else $error("line store read and write hit the same entry");

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_level <= FIFO_LVL_W'(FIFO_DEPTH))
        else $error("output queue overflow");

    a_size_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_size_write |=> (r_col == '0) && (r_row == '0))
        else $error("frame did not restart after a size write");

    a_last_is_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tlast) |-> o_m_axis_tdata[21])
        else $error("frame end word without run end");

endmodule

`default_nettype wire

// ----- test/binary_thinning_subpass_core_checker.sv -----
`timescale 1ns / 100ps

package btsp_tb_pkg;

    typedef enum logic [1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1,
        REG_SUBPASS      = 2'd2,
        REG_UNUSED       = 2'd3
    } cfg_reg_e;

endpackage

module binary_thinning_subpass_core_checker (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_s_tvalid,
    input  wire logic                            i_s_tready,
    input  wire logic [btsp_pkg::S_TDATA_W-1:0]  i_s_tdata,   // pixel_in
    input  wire logic                            i_m_tvalid,
    input  wire logic                            i_m_tready,
    // out_row, out_col, pixel_out, run_end
    input  wire logic [btsp_pkg::M_TDATA_W-1:0]  i_m_tdata,
    input  wire logic                            i_m_tuser,   // removed
    input  wire logic                            i_m_tlast,
    input  wire logic                            i_cfg_we,
    input  wire logic [btsp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [btsp_pkg::CFG_W-1:0]      i_cfg_data,
    output int                                   o_fail_count,
    output int                                   o_pending,
    output int                                   o_word_count
);
    import btsp_pkg::*;
    import btsp_tb_pkg::*;

    logic [CFG_W-1:0]          width_reg;
    logic [CFG_W-1:0]          height_reg;
    logic                      subpass_reg;
    logic [DEF_MAX_WIDTH-1:0]  upper_line;
    logic [DEF_MAX_WIDTH-1:0]  middle_line;
    logic [8:0]                nbhd;
    int unsigned               cur_row;
    int unsigned               cur_col;
    t_result                   due_results[$];
    int                        fails = 0;
    int                        words = 0;

    function automatic int unsigned eff_size(input logic [CFG_W-1:0] v, input int unsigned hi);
        if (v < 3) return 3;
        if (v > hi) return hi;
        return v;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endtask

    // The window holds three columns of three rows; bit (col * 3 + row), col 0 oldest.
    task automatic thin_pixel(input logic pix);
        int unsigned w;
        int unsigned h;
        int unsigned r;
        int unsigned c;
        int unsigned set_cnt;
        int unsigned rises;
        logic        last_row;
        logic        last_col;
        logic        edge_val;
        logic        ctr;
        logic        prod_a;
        logic        prod_b;
        logic [7:0]  ring;
        t_result     res;
        w = eff_size(width_reg, DEF_MAX_WIDTH);
        h = eff_size(height_reg, DEF_MAX_HEIGHT);
        r = cur_row;
        c = cur_col;
        last_row = (r >= h - 1);
        last_col = (c >= w - 1);
        edge_val = middle_line[w - 1];
        nbhd = {pix, middle_line[c], upper_line[c], nbhd[8:3]};
        upper_line[c] = middle_line[c];
        middle_line[c] = pix;

        if (r >= 2) begin
            res = '0;
            res.row = COORD_W'(r - 1);
            if (c == 0) begin
                res.col   = COORD_W'(w - 1);
                res.pixel = edge_val;
            end else begin
                ctr = nbhd[4];
                res.col   = COORD_W'(c - 1);
                res.pixel = ctr;
                if (c >= 2) begin
                    // Ring order from the bottom bit: N, NE, E, SE, S, SW, W, NW.
                    ring = {nbhd[0], nbhd[1], nbhd[2], nbhd[5],
                            nbhd[8], nbhd[7], nbhd[6], nbhd[3]};
                    rises = 0;
                    set_cnt = 0;
                    for (int i = 0; i < 8; i++) begin
                        set_cnt += ring[i];
                        if (!ring[i] && ring[(i + 1) % 8]) rises++;
                    end
                    if (subpass_reg) begin
                        prod_a = ring[0] & ring[2] & ring[6];
                        prod_b = ring[0] & ring[4] & ring[6];
                    end else begin
                        prod_a = ring[0] & ring[2] & ring[4];
                        prod_b = ring[2] & ring[4] & ring[6];
                    end
                    if (ctr && rises == 1 && set_cnt >= 2 && set_cnt <= 6
                        && !prod_a && !prod_b) begin
                        res.pixel   = 1'b0;
                        res.removed = 1'b1;
                    end
                end
            end
            res.run_end = !(r == 0 || last_row);
            due_results.push_back(res);
        end
        if (r == 0 || last_row) begin
            res = '0;
            res.row       = COORD_W'(r);
            res.col       = COORD_W'(c);
            res.pixel     = pix;
            res.run_end   = 1'b1;
            res.frame_end = last_row && last_col;
            due_results.push_back(res);
        end

        if (last_col) begin
            cur_col = 0;
            cur_row = last_row ? 0 : r + 1;
        end else begin
            cur_col = c + 1;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            width_reg   = CFG_W'(DEF_MAX_WIDTH);
            height_reg  = CFG_W'(DEF_MAX_HEIGHT);
            subpass_reg = 1'b0;
            upper_line  = '0;
            middle_line = '0;
            nbhd        = '0;
            cur_row     = 0;
            cur_col     = 0;
            due_results.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got.row       = i_m_tdata[9:0];
                got.col       = i_m_tdata[19:10];
                got.pixel     = i_m_tdata[20];
                got.run_end   = i_m_tdata[21];
                got.removed   = i_m_tuser;
                got.frame_end = i_m_tlast;
                words++;
                if (due_results.size() == 0) begin
                    $error("Output word with no result due: row %0d, col %0d",
                           got.row, got.col);
                    fails++;
                end else begin
                    want = due_results.pop_front();
                    check_field("out_row", want.row, got.row);
                    check_field("out_col", want.col, got.col);
                    check_field("pixel_out", want.pixel, got.pixel);
                    check_field("removed", want.removed, got.removed);
                    check_field("run_end", want.run_end, got.run_end);
                    check_field("frame_end", want.frame_end, got.frame_end);
                end
            end
            if (i_cfg_we) begin
                case (cfg_reg_e'(i_cfg_index))
                    REG_FRAME_WIDTH: begin
                        width_reg = i_cfg_data;
                        cur_row   = 0;
                        cur_col   = 0;
                    end
                    REG_FRAME_HEIGHT: begin
                        height_reg = i_cfg_data;
                        cur_row    = 0;
                        cur_col    = 0;
                    end
                    REG_SUBPASS: begin
                        subpass_reg = i_cfg_data[0];
                    end
                    default: begin
                    end
                endcase
            end
            if (i_s_tvalid && i_s_tready) thin_pixel(i_s_tdata[0]);
        end
        o_fail_count <= fails;
        o_pending    <= due_results.size();
        o_word_count <= words;
    end

endmodule

// ----- test/binary_thinning_subpass_core_tb.sv -----
`timescale 1ns / 100ps

module binary_thinning_subpass_core_tb;
    import btsp_pkg::*;
    import btsp_tb_pkg::*;

    localparam int SETTLE_CYCLES = 12;
    localparam int PHASE_ITEMS   = 240;
    localparam int EDGE_ITEMS    = 48;

    // Raster order, first pixel in bit 0: a thick stroke that only the second
    // sub-iteration may thin at the center.
    localparam logic [8:0] STROKE_IMG = 9'b111_111_000;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_W-1:0]      cfg_data  = '0;

    int fail_count;
    int pending;
    int word_count;
    int send_gap_pct = 0;
    int stall_pct    = 0;
    int pixels_sent  = 0;
    int frames_done  = 0;

    binary_thinning_subpass_core u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .o_m_axis_tlast  (m_tlast),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    binary_thinning_subpass_core_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .i_m_tlast    (m_tlast),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_word_count (word_count)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    initial begin
        #5_000_000;
        $display("binary_thinning_subpass_core regression: fail");
        $finish;
    end

    always @(posedge clk) begin
        m_tready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
    end

    function automatic int eff_dim(input int v);
        if (v < 3) return 3;
        if (v > 1024) return 1024;
        return v;
    endfunction

    task automatic send_pixel(input logic pix);
        while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W - 1){1'b0}}, pix};
        do @(posedge clk); while (!s_tready);
        pixels_sent++;
    endtask

    // Waits until every result is out, then lets the pipeline settle.
    task automatic drain_block();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_e idx, input logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    task automatic configure(input int w_raw, input int h_raw, input logic [CFG_W-1:0] sp);
        drain_block();
        write_reg(REG_FRAME_WIDTH, CFG_W'(w_raw));
        write_reg(REG_FRAME_HEIGHT, CFG_W'(h_raw));
        write_reg(REG_SUBPASS, sp);
        cfg_we <= 1'b0;
    endtask

    task automatic send_image(input logic [8:0] img);
        for (int i = 0; i < 9; i++) send_pixel(img[i]);
    endtask

    task automatic send_frame(input int w, input int h, input int len);
        int   kind;
        int   density;
        int   r0;
        int   r1;
        int   c0;
        int   c1;
        int   r;
        int   c;
        logic pix;
        kind    = $urandom_range(1);
        density = ($urandom_range(3) == 0) ? 100 * $urandom_range(1) : $urandom_range(15, 85);
        r0      = $urandom_range(h - 1);
        r1      = $urandom_range(h - 1, r0);
        c0      = $urandom_range(w - 1);
        c1      = $urandom_range(w - 1, c0);
        for (int n = 0; n < len; n++) begin
            r = n / w;
            c = n % w;
            if (c == 0 && r > 0 && $urandom_range(5) == 0) begin
                drain_block();
                if ($urandom_range(1) == 1) begin
                    write_reg(REG_SUBPASS, CFG_W'($urandom));
                    cfg_we <= 1'b0;
                end
            end
            if (kind == 0) begin
                pix = ($urandom_range(99) < density);
            end else begin
                pix = (r >= r0 && r <= r1 && c >= c0 && c <= c1) ^ ($urandom_range(24) == 0);
            end
            send_pixel(pix);
        end
        if (len == w * h) frames_done++;
    endtask

    task automatic random_frame();
        int w_raw;
        int h_raw;
        int len;
        w_raw = ($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(12, 3);
        h_raw = ($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(8, 3);
        len   = eff_dim(w_raw) * eff_dim(h_raw);
        if ($urandom_range(6) == 0) len = $urandom_range(len - 1, 1);
        configure(w_raw, h_raw, CFG_W'($urandom));
        send_frame(eff_dim(w_raw), eff_dim(h_raw), len);
    endtask

    initial begin
        int target;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Reset sizes and sub-pass, then the smallest image under both sub-passes.
        send_pixel(1'b1);
        send_pixel(1'b0);
        send_pixel(1'b1);
        drain_block();
        write_reg(REG_UNUSED, CFG_W'($urandom));
        cfg_we <= 1'b0;
        configure(0, 2, '0);
        send_image(STROKE_IMG);
        drain_block();
        write_reg(REG_SUBPASS, 11'h7FF);
        cfg_we <= 1'b0;
        send_image(STROKE_IMG);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    send_gap_pct = 0;
                    stall_pct    = 0;
                end
                1: begin
                    send_gap_pct = 49;
                    stall_pct    = 0;
                end
                2: begin
                    send_gap_pct = 0;
                    stall_pct    = 49;
                end
                default: begin
                    send_gap_pct = 12;
                    stall_pct    = 12;
                end
            endcase
            target = pixels_sent + PHASE_ITEMS;
            while (pixels_sent < target) random_frame();
        end

        // Sizes above the maximum: the first pixels of the widest row, then of the
        // tallest image with the narrowest rows.
        configure(2047, 1, CFG_W'($urandom));
        send_frame(1024, 3, EDGE_ITEMS);
        configure(3, 2047, CFG_W'($urandom));
        send_frame(3, 1024, EDGE_ITEMS);

        drain_block();
        $display("Streamed %0d pixels (%0d complete images) and checked %0d output words,",
                 pixels_sent, frames_done, word_count);
        $display("covering clamped sizes, both sub-passes, mid-image writes and port stalls.");
        if (fail_count == 0 && pending == 0) begin
            $display("binary_thinning_subpass_core regression: pass");
        end else begin
            $display("binary_thinning_subpass_core regression: fail");
        end
        $finish;
    end

endmodule
